>>> hdl/tcm_pkg.sv
package tcm_pkg;

  // Notch ranges
  localparam int DRIVE_STEPS = 31;
  localparam int BRAKE_STEPS = 15;

  // Electrical constants
  localparam int CATENARY_MV  = 1500000;
  localparam int EMF_PER_KMH  = 6000;
  localparam int R_MAX_MOHM   = 1000;
  localparam int R_MIN_MOHM   = 300;
  localparam int R_SPAN_MOHM  = R_MAX_MOHM - R_MIN_MOHM;
  localparam int CURRENT_FS_A = 2000;
  localparam int METER_FS     = 3750;
  localparam int SENSE_FACTOR = 600;
  localparam int SENSE_DIV    = 1000;
  localparam int OVER_LIMIT_A = 1800;

  // floor(SENSE_FACTOR * mv / SENSE_DIV) > OVER_LIMIT_A  <=>  mv >= OVER_MV
  localparam int OVER_MV = ((OVER_LIMIT_A + 1) * SENSE_DIV + SENSE_FACTOR - 1) / SENSE_FACTOR;

  // meter = current * 3750 / 2000 = current * 15 / 8, exact
  localparam int METER_SHIFT = 3;
  localparam int METER_MUL   = METER_FS * (1 << METER_SHIFT) / CURRENT_FS_A;

  // Field widths
  localparam int STEP_W  = 6;
  localparam int SPEED_W = 8;
  localparam int MV_W    = 12;
  localparam int CFG_W   = 5;
  localparam int METER_W = 12;
  localparam int CUR_W   = 11;

  // Internal widths
  localparam int NOTCH_W = 5;   // zone position and zone length
  localparam int RN_W    = 15;  // 700 * position
  localparam int RCP_W   = 21;  // ceil(2^20 / len)
  localparam int RCP_SH  = 20;
  localparam int PROD_W  = RN_W + RCP_W;
  localparam int RES_W   = 10;  // resistance, 300..1000 mohm
  localparam int EMF_W   = 21;  // speed * 6000
  localparam int NUM_W   = 21;  // catenary minus emf
  localparam int DEN_W   = RES_W + 1;
  localparam int QUOT_W  = 13;  // up to 1500000 / 300
  localparam int REM_W   = DEN_W;
  localparam int MSCALE_W = CUR_W + 4;

  // Long division: bits of quotient per pipeline stage
  localparam int DIV_BITS   = 3;
  localparam int DIV_STAGES = (QUOT_W + DIV_BITS - 1) / DIV_BITS;

  // Reciprocals for exact floor(n / len), n < 2^15, len 1..31
  localparam logic [RCP_W-1:0] RECIP [32] = '{
    21'd0,       21'd1048576, 21'd524288,  21'd349526,
    21'd262144,  21'd209716,  21'd174763,  21'd149797,
    21'd131072,  21'd116509,  21'd104858,  21'd95326,
    21'd87382,   21'd80660,   21'd74899,   21'd69906,
    21'd65536,   21'd61681,   21'd58255,   21'd55189,
    21'd52429,   21'd49933,   21'd47663,   21'd45591,
    21'd43691,   21'd41944,   21'd40330,   21'd38837,
    21'd37450,   21'd36158,   21'd34953,   21'd33826
  };

  typedef struct packed {
    logic signed [STEP_W-1:0] notch;
    logic [SPEED_W-1:0]       speed;
    logic                     coupling_series;
    logic [MV_W-1:0]          sense_mv;
  } tcm_in_t;

  typedef struct packed {
    logic [METER_W-1:0] meter_code;
    logic [CUR_W-1:0]   model_current_a;
    logic               overcurrent;
  } tcm_out_t;

endpackage

>>> hdl/tcm_divider.sv
module tcm_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      start,
  input  logic [tcm_pkg::NUM_W-1:0] num,
  input  logic [tcm_pkg::DEN_W-1:0] den,
  input  logic                      ovc_in,
  output logic                      done,
  output logic [tcm_pkg::QUOT_W-1:0] quot,
  output logic                      ovc_out
);
  import tcm_pkg::*;

  logic              valid [DIV_STAGES];
  logic [REM_W-1:0]  rem   [DIV_STAGES];
  logic [QUOT_W-1:0] nlo   [DIV_STAGES];
  logic [QUOT_W-1:0] quo   [DIV_STAGES];
  logic [DEN_W-1:0]  dreg  [DIV_STAGES];
  logic              ovc   [DIV_STAGES];

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stg
    logic              v_in;
    logic [REM_W-1:0]  r_in;
    logic [QUOT_W-1:0] n_in;
    logic [QUOT_W-1:0] q_in;
    logic [DEN_W-1:0]  d_in;
    logic              o_in;
    logic [REM_W-1:0]  r_c;
    logic [QUOT_W-1:0] n_c;
    logic [QUOT_W-1:0] q_c;
    logic [REM_W:0]    trial;

    if (g == 0) begin : g_first
      // upper numerator bits are always below the divisor (>= 300)
      assign v_in = start;
      assign r_in = REM_W'(num[NUM_W-1:QUOT_W]);
      assign n_in = num[QUOT_W-1:0];
      assign q_in = '0;
      assign d_in = den;
      assign o_in = ovc_in;
    end else begin : g_next
      assign v_in = valid[g-1];
      assign r_in = rem[g-1];
      assign n_in = nlo[g-1];
      assign q_in = quo[g-1];
      assign d_in = dreg[g-1];
      assign o_in = ovc[g-1];
    end

    always_comb begin
      r_c   = r_in;
      n_c   = n_in;
      q_c   = q_in;
      trial = '0;
      for (int k = 0; k < DIV_BITS; k++) begin
        if (g * DIV_BITS + k < QUOT_W) begin
          trial = {r_c, n_c[QUOT_W-1]};
          n_c   = {n_c[QUOT_W-2:0], 1'b0};
          if (trial >= {1'b0, d_in}) begin
            r_c = REM_W'(trial - {1'b0, d_in});
            q_c = {q_c[QUOT_W-2:0], 1'b1};
          end else begin
            r_c = trial[REM_W-1:0];
            q_c = {q_c[QUOT_W-2:0], 1'b0};
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[g] <= 1'b0;
      end else if (en) begin
        valid[g] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[g]  <= r_c;
        nlo[g]  <= n_c;
        quo[g]  <= q_c;
        dreg[g] <= d_in;
        ovc[g]  <= o_in;
      end
    end
  end

  assign done    = valid[DIV_STAGES-1];
  assign quot    = quo[DIV_STAGES-1];
  assign ovc_out = ovc[DIV_STAGES-1];

endmodule

>>> hdl/traction_current_meter_model.sv
// The pipeline has 4 stages to build resistance and EMF, 5 long-division stages
//   and 1 output register.
// Throughput: one beat per cycle; the whole pipeline holds while a result
//   waits on out_stall, so in_stall follows out_valid & out_stall.
// Reset (rst, synchronous): empties the pipeline, series_last_step back to 15.
module traction_current_meter_model (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_wr_en,
  input  logic [tcm_pkg::CFG_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  tcm_pkg::tcm_in_t          in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output tcm_pkg::tcm_out_t         out_data
);
  import tcm_pkg::*;

  logic [CFG_W-1:0] series_last_step;
  logic             en;

  // stage 1: zone decode, emf
  logic [NOTCH_W-1:0] last;
  logic [NOTCH_W-1:0] s;
  logic [STEP_W-1:0]  mag;
  logic [NOTCH_W-1:0] pos;
  logic [NOTCH_W-1:0] len;
  logic               s1_valid;
  logic [NOTCH_W-1:0] s1_pos;
  logic [NOTCH_W-1:0] s1_len;
  logic               s1_off;
  logic [EMF_W-1:0]   s1_emf;
  logic               s1_ser;
  logic               s1_ovc;

  // stage 2: numerators, reciprocal
  logic [EMF_W:0]     emf_c;
  logic [NUM_W-1:0]   num_c;
  logic               s2_valid;
  logic [RN_W-1:0]    s2_rn;
  logic [RCP_W-1:0]   s2_rcp;
  logic [NUM_W-1:0]   s2_num;
  logic               s2_ser;
  logic               s2_ovc;

  // stage 3: resistance drop
  logic [PROD_W-1:0]  prod;
  logic               s3_valid;
  logic [RES_W-1:0]   s3_drop;
  logic [NUM_W-1:0]   s3_num;
  logic               s3_ser;
  logic               s3_ovc;

  // stage 4: divisor
  logic [RES_W-1:0]   res_c;
  logic               s4_valid;
  logic [DEN_W-1:0]   s4_den;
  logic [NUM_W-1:0]   s4_num;
  logic               s4_ovc;

  // divider and output
  logic                div_done;
  logic [QUOT_W-1:0]   div_quot;
  logic                div_ovc;
  logic [CUR_W-1:0]    cur;
  logic [MSCALE_W-1:0] scaled;

  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      series_last_step <= CFG_W'(15);
    end else if (cfg_wr_en) begin
      series_last_step <= cfg_wr_data;
    end
  end

  // out-of-range register values are clamped so both zones have length >= 1
  always_comb begin
    if (series_last_step < NOTCH_W'(1)) begin
      last = NOTCH_W'(1);
    end else if (series_last_step > CFG_W'(DRIVE_STEPS - 2)) begin
      last = NOTCH_W'(DRIVE_STEPS - 2);
    end else begin
      last = series_last_step;
    end
  end

  always_comb begin
    s   = '0;
    mag = '0;
    if (in_data.notch > 0) begin
      s = (in_data.notch > DRIVE_STEPS) ? NOTCH_W'(DRIVE_STEPS)
                                        : NOTCH_W'(in_data.notch);
      if (s <= last) begin
        pos = s;
        len = last;
      end else begin
        pos = s - last - NOTCH_W'(1);
        len = NOTCH_W'(DRIVE_STEPS) - last - NOTCH_W'(1);
      end
    end else begin
      mag = STEP_W'(-in_data.notch);
      pos = (mag > BRAKE_STEPS) ? NOTCH_W'(BRAKE_STEPS) : NOTCH_W'(mag);
      len = NOTCH_W'(BRAKE_STEPS);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_pos <= pos;
      s1_len <= len;
      s1_off <= (in_data.notch == '0);
      s1_emf <= EMF_W'(in_data.speed) * EMF_W'(EMF_PER_KMH);
      s1_ser <= in_data.coupling_series;
      s1_ovc <= (in_data.sense_mv >= MV_W'(OVER_MV));
    end
  end

  // series coupling doubles the emf; no current at or above catenary voltage
  always_comb begin
    emf_c = s1_ser ? {s1_emf, 1'b0} : {1'b0, s1_emf};
    if (s1_off || emf_c >= (EMF_W + 1)'(CATENARY_MV)) begin
      num_c = '0;
    end else begin
      num_c = NUM_W'((EMF_W + 1)'(CATENARY_MV) - emf_c);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_rn  <= RN_W'(s1_pos) * RN_W'(R_SPAN_MOHM);
      s2_rcp <= RECIP[s1_len];
      s2_num <= num_c;
      s2_ser <= s1_ser;
      s2_ovc <= s1_ovc;
    end
  end

  // floor(700 * pos / len), never above 700
  assign prod = PROD_W'(s2_rn) * PROD_W'(s2_rcp);

  always_ff @(posedge clk) begin
    if (en) begin
      s3_drop <= prod[RCP_SH +: RES_W];
      s3_num  <= s2_num;
      s3_ser  <= s2_ser;
      s3_ovc  <= s2_ovc;
    end
  end

  assign res_c = RES_W'(R_MAX_MOHM) - s3_drop;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_den <= s3_ser ? {res_c, 1'b0} : {1'b0, res_c};
      s4_num <= s3_num;
      s4_ovc <= s3_ovc;
    end
  end

  tcm_divider u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .start   (s4_valid),
    .num     (s4_num),
    .den     (s4_den),
    .ovc_in  (s4_ovc),
    .done    (div_done),
    .quot    (div_quot),
    .ovc_out (div_ovc)
  );

  assign cur    = (div_quot > QUOT_W'(CURRENT_FS_A)) ? CUR_W'(CURRENT_FS_A)
                                                     : div_quot[CUR_W-1:0];
  assign scaled = MSCALE_W'(cur) * MSCALE_W'(METER_MUL);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= div_done;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.meter_code      <= METER_W'(scaled >> METER_SHIFT);
      out_data.model_current_a <= cur;
      out_data.overcurrent     <= div_ovc;
    end
  end

endmodule

>>> hdl/tcm_checker.sv
module tcm_props (
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input tcm_pkg::tcm_out_t   out_data
);
  import tcm_pkg::*;

  logic [MSCALE_W-1:0] scaled;

  assign scaled = MSCALE_W'(out_data.model_current_a) * MSCALE_W'(METER_MUL);

  // a waiting beat holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // input side is held back only by a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output back-pressure");

  a_cur_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.model_current_a <= CUR_W'(CURRENT_FS_A))
    else $error("current above full scale");

  a_meter: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.meter_code == METER_W'(scaled >> METER_SHIFT))
    else $error("meter code does not match current");

endmodule

bind traction_current_meter_model tcm_props u_tcm_props (.*);
